>>> src/scancode_to_ascii_fifo_assert.svh
// Assertion macros used by the scancode to ASCII FIFO back end.
`ifndef SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define SC2A_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled in reset
`define SC2A_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SC2A_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SC2A_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/sc2a_pkg.sv
// Package: constants, ASCII tables and command type for the scancode to ASCII FIFO.
package sc2a_pkg;

   localparam int FIFO_DEPTH = 128;
   localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
   localparam int TABLE_LEN  = 58;

   // request opcodes
   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   // set-1 scancodes of interest
   localparam logic [7:0] SC_LSHIFT     = 8'h2A;
   localparam logic [7:0] SC_RSHIFT     = 8'h36;
   localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
   localparam logic [7:0] SC_CTRL       = 8'h1D;
   localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
   localparam logic [7:0] SC_CAPS       = 8'h3A;

   localparam logic [6:0] CH_LOWER_A = 7'h61;
   localparam logic [6:0] CH_LOWER_Z = 7'h7A;
   localparam logic [6:0] CH_LOWER_C = 7'h63;
   localparam logic [6:0] CH_UPPER_C = 7'h43;
   localparam logic [6:0] CH_ETX     = 7'h03;

   // back-end command kinds
   localparam logic [1:0] CMD_NOP   = 2'd0;
   localparam logic [1:0] CMD_PUSH  = 2'd1;
   localparam logic [1:0] CMD_POP   = 2'd2;
   localparam logic [1:0] CMD_FLUSH = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] ch;
   } cmd_type;

   localparam logic [6:0] PLAIN_MAP [TABLE_LEN] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   localparam logic [6:0] UPPER_MAP [TABLE_LEN] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

endpackage

>>> src/sc2a_front.sv
// Front end: accepts items, tracks modifiers and maps scancodes to commands.
module sc2a_front import sc2a_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_scan_byte,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   logic       shift_ff, shift_in;
   logic       ctrl_ff, ctrl_in;
   logic       caps_ff, caps_in;
   logic       accept;
   logic [5:0] tidx;
   logic [6:0] plain_ch, upper_ch, ch;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;
   assign tidx      = req_scan_byte[5:0];
   assign plain_ch  = PLAIN_MAP[tidx];
   assign upper_ch  = UPPER_MAP[tidx];

   always_comb begin
      ch = shift_ff ? upper_ch : plain_ch;
      if (!shift_ff && caps_ff && plain_ch >= CH_LOWER_A && plain_ch <= CH_LOWER_Z) begin
         ch = upper_ch;
      end
      if (ctrl_ff && (ch == CH_LOWER_C || ch == CH_UPPER_C)) begin
         ch = CH_ETX;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      caps_in  = caps_ff;
      cmd.kind = CMD_NOP;
      cmd.ch   = '0;
      unique case (req_opcode)
         OP_SCAN: begin
            unique case (req_scan_byte) inside
               SC_LSHIFT, SC_RSHIFT:         shift_in = 1'b1;
               SC_LSHIFT_REL, SC_RSHIFT_REL: shift_in = 1'b0;
               SC_CTRL:                      ctrl_in  = 1'b1;
               SC_CTRL_REL:                  ctrl_in  = 1'b0;
               SC_CAPS:                      caps_in  = !caps_ff;
               default: begin
                  // break codes and codes past the table give nothing
                  if (req_scan_byte < 8'(TABLE_LEN) && ch != '0) begin
                     cmd.kind = CMD_PUSH;
                     cmd.ch   = ch;
                  end
               end
            endcase
         end
         OP_READ:  cmd.kind = CMD_POP;
         OP_FLUSH: cmd.kind = CMD_FLUSH;
         default:  cmd.kind = CMD_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         caps_ff  <= 1'b0;
      end else if (accept) begin
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         caps_ff  <= caps_in;
      end
   end

endmodule

>>> src/sc2a_cmdq.sv
// Two-entry command queue between the front and back ends.
module sc2a_cmdq import sc2a_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> src/sc2a_back.sv
// Back end: character ring buffer and registered result stage.
`include "scancode_to_ascii_fifo_assert.svh"
module sc2a_back import sc2a_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_key_char,
   output logic       rsp_key_valid,
   output logic       rsp_key_pending,
   output logic       rsp_overflow_drop
);

   localparam logic [FIFO_IDX_W-1:0] LAST_IDX = FIFO_IDX_W'(FIFO_DEPTH - 1);

   logic [6:0]            store [FIFO_DEPTH];
   logic [6:0]            rd_data_ff;
   logic [FIFO_IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [FIFO_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [FIFO_IDX_W-1:0] wr_next, rd_next;
   logic                  rsp_valid_ff;
   logic                  kv_ff, kv_in;
   logic                  pend_ff;
   logic                  drop_ff, drop_in;
   logic                  exec;
   logic                  do_write;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign exec      = cmd_valid && cmd_ready;
   assign wr_next   = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
   assign rd_next   = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      kv_in     = 1'b0;
      drop_in   = 1'b0;
      do_write  = 1'b0;
      unique case (cmd.kind)
         CMD_PUSH: begin
            // one slot stays empty, so full is next write index meeting read index
            if (wr_next == rd_idx_ff) begin
               drop_in = 1'b1;
            end else begin
               do_write  = 1'b1;
               wr_idx_in = wr_next;
            end
         end
         CMD_POP: begin
            if (wr_idx_ff != rd_idx_ff) begin
               kv_in     = 1'b1;
               rd_idx_in = rd_next;
            end
         end
         CMD_FLUSH: begin
            wr_idx_in = '0;
            rd_idx_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (exec && do_write) begin
         store[wr_idx_ff] <= cmd.ch;
      end
      if (exec) begin
         rd_data_ff <= store[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         kv_ff   <= kv_in;
         pend_ff <= (wr_idx_in != rd_idx_in);
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec) begin
            wr_idx_ff <= wr_idx_in;
            rd_idx_ff <= rd_idx_in;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_key_char      = kv_ff ? rd_data_ff : '0;
   assign rsp_key_valid     = kv_ff;
   assign rsp_key_pending   = pend_ff;
   assign rsp_overflow_drop = drop_ff;

   `SC2A_ASSERT_NOW(a_drop_means_pending, clock, reset, rsp_valid_ff && drop_ff, pend_ff && !kv_ff, "drop without full buffer")
   `SC2A_ASSERT_NEXT(a_flush_clears, clock, reset, exec && cmd.kind == CMD_FLUSH, wr_idx_ff == '0 && rd_idx_ff == '0 && !pend_ff, "flush left buffer non-empty")
   `SC2A_ASSERT_NEXT(a_nop_keeps_idx, clock, reset, exec && cmd.kind == CMD_NOP, $stable(wr_idx_ff) && $stable(rd_idx_ff), "no-op moved an index")
   `SC2A_ASSERT_NEXT(a_pop_advances, clock, reset, exec && cmd.kind == CMD_POP && wr_idx_ff != rd_idx_ff, kv_ff && rd_idx_ff == $past(rd_next), "pop did not advance read index")

endmodule

>>> src/scancode_to_ascii_fifo.sv
// Top level: set-1 scancode to ASCII converter with a character ring buffer.
// An accepted item passes through the command queue, then the result register, before its result shows.
// Throughput: 1 item per cycle while the result side takes results; the table lookup is combinational.
// Buffer holds FIFO_DEPTH-1 characters; one slot is kept empty to tell full from empty.
// Reset (synchronous, active high) clears modifiers, buffer indices, queue and result valid.
// The character store itself is not cleared; only written entries are ever read.
module scancode_to_ascii_fifo import sc2a_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_key_char,
   output logic       rsp_key_valid,
   output logic       rsp_key_pending,
   output logic       rsp_overflow_drop
);

   // front -> queue
   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;
   // queue -> back
   logic    qb_valid, qb_ready;
   cmd_type qb_cmd;

   // Front end: Shift/Ctrl/Caps tracking and table lookup, one item per cycle while the queue has room.
   sc2a_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_scan_byte (req_scan_byte),
      .cmd_valid     (fq_valid),
      .cmd_ready     (fq_ready),
      .cmd           (fq_cmd)
   );

   // Two-entry queue so that a stalled result holds the front end only once the queue is full.
   sc2a_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   // Back end: push/pop/flush on the ring buffer, registered item out.
   sc2a_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (qb_valid),
      .cmd_ready         (qb_ready),
      .cmd               (qb_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_char      (rsp_key_char),
      .rsp_key_valid     (rsp_key_valid),
      .rsp_key_pending   (rsp_key_pending),
      .rsp_overflow_drop (rsp_overflow_drop)
   );

endmodule

>>> dv/scancode_to_ascii_fifo_tb.sv
// Testbench for scancode_to_ascii_fifo: random and directed key traffic checked against a predictor.
`timescale 1ns / 100ps

module scancode_to_ascii_fifo_tb import sc2a_pkg::*;;

   // opcode 3 is not decoded by the block; it must leave everything alone
   localparam logic [1:0] OP_SPARE = 2'd3;

   // set-1 codes used by the stimulus beyond the modifiers in the package
   localparam logic [7:0] SC_KEY_1     = 8'h02;
   localparam logic [7:0] SC_KEY_A     = 8'h1E;
   localparam logic [7:0] SC_KEY_C     = 8'h2E;
   localparam logic [7:0] SC_ALT       = 8'h38;
   localparam logic [7:0] SC_SPACE     = 8'h39;
   localparam logic [7:0] SC_PAST_MAP  = 8'h3B;
   localparam logic [7:0] SC_LAST_MAKE = 8'h7F;
   localparam logic [7:0] SC_FIRST_BRK = 8'h80;

   // Our own copy of the key maps: unshifted, then shifted.
   localparam logic [6:0] BASE_KEYS [TABLE_LEN] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };
   localparam logic [6:0] SHIFT_KEYS [TABLE_LEN] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   typedef struct packed {
      logic [6:0] ch;
      logic       popped;
      logic       pending;
      logic       dropped;
   } key_result_type;

   // Keyboard and character buffer predictor plus the queue of expected results.
   class keyboard_checker;
      logic [6:0]            char_buf [FIFO_DEPTH];
      logic [FIFO_IDX_W-1:0] wr_ptr;
      logic [FIFO_IDX_W-1:0] rd_ptr;
      bit                    shift_on;
      bit                    ctrl_on;
      bit                    caps_on;
      key_result_type        expected_keys [$];
      int                    errors;

      function new();
         wr_ptr = '0;
         rd_ptr = '0;
      endfunction

      // Work out the result of one accepted item and queue it.
      function void note_request(logic [1:0] op, logic [7:0] code);
         key_result_type        r;
         logic [6:0]            ch;
         logic [FIFO_IDX_W-1:0] nxt;
         r = '0;
         case (op)
            OP_SCAN: begin
               if (code == SC_LSHIFT || code == SC_RSHIFT) shift_on = 1'b1;
               else if (code == SC_LSHIFT_REL || code == SC_RSHIFT_REL) shift_on = 1'b0;
               else if (code == SC_CTRL) ctrl_on = 1'b1;
               else if (code == SC_CTRL_REL) ctrl_on = 1'b0;
               else if (code == SC_CAPS) caps_on = !caps_on;
               else if (code < TABLE_LEN) begin
                  ch = shift_on ? SHIFT_KEYS[code[5:0]] : BASE_KEYS[code[5:0]];
                  // caps lock only lifts letters
                  if (!shift_on && caps_on && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                     ch = SHIFT_KEYS[code[5:0]];
                  if (ctrl_on && (ch == CH_LOWER_C || ch == CH_UPPER_C))
                     ch = CH_ETX;
                  if (ch != 7'h00) begin
                     nxt = FIFO_IDX_W'((wr_ptr + 1) % FIFO_DEPTH);
                     if (nxt == rd_ptr) r.dropped = 1'b1;
                     else begin
                        char_buf[wr_ptr] = ch;
                        wr_ptr = nxt;
                     end
                  end
               end
            end
            OP_READ: begin
               if (wr_ptr != rd_ptr) begin
                  r.ch     = char_buf[rd_ptr];
                  r.popped = 1'b1;
                  rd_ptr   = FIFO_IDX_W'((rd_ptr + 1) % FIFO_DEPTH);
               end
            end
            OP_FLUSH: begin
               wr_ptr = '0;
               rd_ptr = '0;
            end
            default: ;
         endcase
         r.pending = (wr_ptr != rd_ptr);
         expected_keys.push_back(r);
      endfunction

      // Compare one accepted result with the oldest expectation.
      function void check_response(logic [6:0] ch, logic popped, logic pending,
                                   logic dropped);
         key_result_type want;
         if (expected_keys.size() == 0) begin
            $display("%0t: unexpected result, key_char %02h", $time, ch);
            errors++;
            return;
         end
         want = expected_keys.pop_front();
         if (ch !== want.ch) begin
            $display("%0t: key_char expected %02h actual %02h", $time, want.ch, ch);
            errors++;
         end
         if (popped !== want.popped) begin
            $display("%0t: key_valid expected %b actual %b", $time, want.popped, popped);
            errors++;
         end
         if (pending !== want.pending) begin
            $display("%0t: key_pending expected %b actual %b", $time, want.pending,
                     pending);
            errors++;
         end
         if (dropped !== want.dropped) begin
            $display("%0t: overflow_drop expected %b actual %b", $time, want.dropped,
                     dropped);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_opcode;
   logic [7:0] req_scan_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [6:0] rsp_key_char;
   logic       rsp_key_valid;
   logic       rsp_key_pending;
   logic       rsp_overflow_drop;

   keyboard_checker sb;
   bit              calm;        // set for the final stretch: no idling either side
   int              items_sent;

   scancode_to_ascii_fifo u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_scan_byte     (req_scan_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_char      (rsp_key_char),
      .rsp_key_valid     (rsp_key_valid),
      .rsp_key_pending   (rsp_key_pending),
      .rsp_overflow_drop (rsp_overflow_drop)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: check every accepted item against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_key_char, rsp_key_valid, rsp_key_pending,
                           rsp_overflow_drop);
   end

   // Result side back-pressure: ready stretches broken at random by stall bursts;
   // held high once the run goes calm.
   initial begin
      rsp_ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         if (calm)
            @(posedge clock);
         else begin
            repeat ($urandom_range(1, 40)) @(posedge clock);
            if (!calm && $urandom_range(0, 1)) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 11)) @(posedge clock);
            end
         end
      end
   end

   // Present one item, sometimes with a random idle burst ahead of it, and hold it until
   // taken. The prediction is made at the accepting edge.
   task automatic send_item(logic [1:0] op, logic [7:0] code);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_scan_byte <= code;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, code);
      items_sent++;
   endtask

   // Stop sending and wait for every expected item to come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_keys.size() != 0) @(posedge clock);
   endtask

   // Timeout guard
   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int         fills_done;
      int         n;
      logic [7:0] shift_code;
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_SCAN;
      req_scan_byte = 8'h00;
      calm          = 1'b0;
      items_sent    = 0;
      fills_done    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      send_item(OP_READ, 8'h00);              // read on an empty buffer
      send_item(OP_SPARE, 8'hFF);             // unused opcode
      send_item(OP_FLUSH, 8'h00);
      send_item(OP_SCAN, 8'h00);              // table entry with no character
      send_item(OP_SCAN, SC_KEY_A);
      send_item(OP_SCAN, SC_SPACE);           // last table entry
      send_item(OP_SCAN, SC_PAST_MAP);        // past the table
      send_item(OP_SCAN, SC_LAST_MAKE);
      send_item(OP_SCAN, SC_ALT);             // Alt is not tracked
      send_item(OP_SCAN, SC_FIRST_BRK);       // plain break code, ignored
      send_item(OP_SCAN, 8'hFF);
      send_item(OP_SCAN, SC_LSHIFT);
      send_item(OP_SCAN, SC_KEY_A);
      send_item(OP_SCAN, SC_KEY_1);
      send_item(OP_SCAN, SC_LSHIFT_REL);
      send_item(OP_SCAN, SC_RSHIFT);
      send_item(OP_SCAN, SC_KEY_C);
      send_item(OP_SCAN, SC_RSHIFT_REL);
      send_item(OP_SCAN, SC_CAPS);            // caps on: letters only
      send_item(OP_SCAN, SC_KEY_A);
      send_item(OP_SCAN, SC_KEY_1);
      send_item(OP_SCAN, SC_CTRL);
      send_item(OP_SCAN, SC_KEY_C);           // ctrl-C gives ETX
      send_item(OP_SCAN, SC_CTRL_REL);
      send_item(OP_SCAN, SC_CAPS);
      repeat (3) send_item(OP_READ, 8'($urandom_range(0, 255)));

      // hold off until everything is back
      drain_results();

      // --- random part ---
      while (items_sent < 800) begin
         if (items_sent >= 720) calm = 1'b1;

         // twice in the run: fill the buffer past full, then empty it
         if ((fills_done == 0 && items_sent >= 150) ||
             (fills_done == 1 && items_sent >= 450)) begin
            fills_done++;
            drain_results();
            send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
            repeat (FIFO_DEPTH + 3) send_item(OP_SCAN, 8'($urandom_range(8'h10, 8'h19)));
            repeat (FIFO_DEPTH + 2) send_item(OP_READ, 8'($urandom_range(0, 255)));
         end

         case ($urandom_range(0, 99)) inside
            [0:39]: begin
               // a typed word, sometimes shifted, reads mixed in
               shift_code = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
               n = $urandom_range(0, 2);
               if (n == 0) send_item(OP_SCAN, shift_code);
               repeat ($urandom_range(1, 8)) begin
                  send_item(OP_SCAN, 8'($urandom_range(0, TABLE_LEN - 1)));
                  if ($urandom_range(0, 9) < 3)
                     send_item(OP_READ, 8'($urandom_range(0, 255)));
               end
               if (n == 0)
                  send_item(OP_SCAN, (shift_code == SC_LSHIFT) ? SC_LSHIFT_REL
                                                               : SC_RSHIFT_REL);
            end
            [40:54]: begin
               send_item(OP_SCAN, SC_CTRL);
               send_item(OP_SCAN, $urandom_range(0, 3) == 0 ? SC_KEY_A : SC_KEY_C);
               send_item(OP_SCAN, SC_CTRL_REL);
            end
            [55:64]: send_item(OP_SCAN, SC_CAPS);
            [65:81]: repeat ($urandom_range(1, 8))
                        send_item(OP_READ, 8'($urandom_range(0, 255)));
            [82:85]: send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
            default: begin
               // noise: any opcode, any byte
               repeat ($urandom_range(1, 4))
                  send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
         endcase
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_keys.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> scancode_to_ascii_fifo.f
+incdir+src
src/sc2a_pkg.sv
src/sc2a_front.sv
src/sc2a_cmdq.sv
src/sc2a_back.sv
src/scancode_to_ascii_fifo.sv
dv/scancode_to_ascii_fifo_tb.sv
